@@ rtl/core/bba_pkg.sv @@
// Shared types, codes and default sizes for the buddy block allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bba_pkg;

	localparam int BLOCKS_DEF    = 1024;
	localparam int ORDER_CAP_DEF = 20;
	localparam int CFG_W         = 11;

	localparam logic [7:0] MARK_INTERIOR = 8'h80;

	localparam logic [1:0] REQ_INIT  = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOMEM    = 2'd1;
	localparam logic [1:0] ST_BADARG   = 2'd2;
	localparam logic [1:0] ST_NOTALLOC = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [4:0] order;
		logic [9:0] block_index;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] result_index;
	} rsp_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_CLR, OP_INIT_START, OP_INIT_T, OP_INIT_ORD, OP_INIT_PUSH,
		OP_FND_DEC, OP_SET_READY, OP_SCAN, OP_POPRD, OP_POP, OP_SPLIT, OP_MARK,
		OP_FREE_RD, OP_FREE_CLR, OP_BUD_RD, OP_WALK_START, OP_NL_RD, OP_UNLINK,
		OP_ADV, OP_PUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       post;
		logic [1:0] code;
		logic       take;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic init_bad;
		logic t_grow;
		logic fit;
		logic rem_zero;
		logic alc_bad;
		logic head_empty;
		logic fnd_top;
		logic fnd_above;
		logic free_bad;
		logic mark_ok;
		logic mrg_can;
		logic bud_free;
		logic cur_end;
		logic cur_hit;
	} sts_t;

endpackage

@@ rtl/core/bba_datapath.sv @@
// Datapath of the buddy block allocator: block map and link memories, free list
// heads, working registers and the response register. Depends on bba_pkg.
module bba_datapath #(
	parameter int BLOCKS    = bba_pkg::BLOCKS_DEF,
	parameter int ORDER_CAP = bba_pkg::ORDER_CAP_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [bba_pkg::CFG_W-1:0] cfg_data,
	input  bba_pkg::req_t             req,
	input  bba_pkg::cmd_t             cmd,
	output bba_pkg::sts_t             sts,
	output bba_pkg::rsp_t             rsp
);
	import bba_pkg::*;

	localparam int IW = $clog2(BLOCKS);
	localparam int SW = IW + 1;
	localparam int OW = $clog2(ORDER_CAP + 1);
	localparam logic [SW-1:0] EMPTY = SW'(BLOCKS);
	localparam logic [CFG_W-1:0] CFG_RST = CFG_W'((BLOCKS < 1024) ? BLOCKS : 1024);

	logic [CFG_W-1:0] cfg_q;
	logic             ready_q;
	logic [4:0]       top_q;
	logic [IW-1:0]    clr_q;
	logic [SW-1:0]    head_q [0:ORDER_CAP];

	logic [SW-1:0] size_q, rem_q, prev_q, cur_q;
	logic [IW-1:0] idx_q, bud_q;
	logic [4:0]    ord_q, fnd_q;
	logic          big_q;
	rsp_t          rsp_q;

	logic [7:0]    bm_mem [0:BLOCKS-1];
	logic [SW-1:0] nl_mem [0:BLOCKS-1];
	logic [7:0]    bm_rd_q;
	logic [SW-1:0] nl_rd_q;

	logic [SW-1:0] pw_fnd, pw_ord, pw_dn, head_rd, lh_wd, nl_wd;
	logic [SW:0]   two_top;
	logic [4:0]    fnd_m1, lh_sel;
	logic [IW-1:0] bud, split_addr, bm_wa, bm_ra, nl_wa, nl_ra;
	logic [7:0]    bm_wd;
	logic          bm_we, nl_we, lh_we;

	assign pw_fnd     = SW'(1) << fnd_q;
	assign pw_ord     = SW'(1) << ord_q;
	assign fnd_m1     = fnd_q - 5'd1;
	assign pw_dn      = SW'(1) << fnd_m1;
	assign two_top    = (SW + 1)'(2) << top_q;
	assign bud        = idx_q ^ pw_ord[IW-1:0];
	assign split_addr = idx_q + pw_dn[IW-1:0];
	assign head_rd    = head_q[lh_sel[OW-1:0]];

	always_comb begin
		lh_sel = fnd_q;
		lh_we  = 1'b0;
		lh_wd  = EMPTY;
		bm_we  = 1'b0;
		bm_wa  = idx_q;
		bm_wd  = MARK_INTERIOR;
		bm_ra  = idx_q;
		nl_we  = 1'b0;
		nl_wa  = idx_q;
		nl_wd  = head_rd;
		nl_ra  = cur_q[IW-1:0];
		case (cmd.op)
			OP_CLR: begin
				bm_we = 1'b1;
				bm_wa = clr_q;
			end
			OP_INIT_PUSH: begin
				bm_we = 1'b1;
				bm_wd = 8'(fnd_q);
				nl_we = 1'b1;
				lh_we = 1'b1;
				lh_wd = {1'b0, idx_q};
			end
			OP_SPLIT: begin
				lh_sel = fnd_m1;
				bm_we  = 1'b1;
				bm_wa  = split_addr;
				bm_wd  = 8'(fnd_m1);
				nl_we  = 1'b1;
				nl_wa  = split_addr;
				lh_we  = 1'b1;
				lh_wd  = {1'b0, split_addr};
			end
			OP_PUSH: begin
				lh_sel = ord_q;
				bm_we  = 1'b1;
				bm_wd  = 8'(ord_q);
				nl_we  = 1'b1;
				lh_we  = 1'b1;
				lh_wd  = {1'b0, idx_q};
			end
			OP_POPRD: begin
				nl_ra = head_rd[IW-1:0];
			end
			OP_POP: begin
				lh_we = 1'b1;
				lh_wd = nl_rd_q;
			end
			OP_MARK: begin
				bm_we = 1'b1;
				bm_wd = 8'd0 - 8'(ord_q) - 8'd2;
			end
			OP_FREE_CLR: begin
				bm_we = 1'b1;
			end
			OP_BUD_RD: begin
				bm_ra = bud;
			end
			OP_WALK_START: begin
				lh_sel = ord_q;
			end
			OP_UNLINK: begin
				lh_sel = ord_q;
				bm_we  = 1'b1;
				bm_wa  = bud_q;
				if (prev_q == EMPTY) begin
					lh_we = 1'b1;
					lh_wd = nl_rd_q;
				end else begin
					nl_we = 1'b1;
					nl_wa = prev_q[IW-1:0];
					nl_wd = nl_rd_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_wa] <= bm_wd;
		end
		bm_rd_q <= bm_mem[bm_ra];
	end

	always_ff @(posedge clk) begin
		if (nl_we) begin
			nl_mem[nl_wa] <= nl_wd;
		end
		nl_rd_q <= nl_mem[nl_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= CFG_RST;
			ready_q <= 1'b0;
			top_q   <= '0;
			clr_q   <= '0;
			for (int i = 0; i <= ORDER_CAP; i++) begin
				head_q[i] <= EMPTY;
			end
		end else begin
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			if (lh_we) begin
				head_q[lh_sel[OW-1:0]] <= lh_wd;
			end
			case (cmd.op)
				OP_CLR:        clr_q <= clr_q + IW'(1);
				OP_INIT_START: top_q <= '0;
				OP_INIT_T:     top_q <= top_q + 5'd1;
				OP_SET_READY:  ready_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ord_q <= req.order;
				fnd_q <= req.order;
				idx_q <= IW'(req.block_index);
				big_q <= 32'(req.block_index) >= 32'(BLOCKS);
			end
			OP_INIT_START: begin
				size_q <= SW'(cfg_q);
				rem_q  <= SW'(cfg_q);
				idx_q  <= '0;
			end
			OP_INIT_ORD: fnd_q <= top_q;
			OP_FND_DEC:  fnd_q <= fnd_m1;
			OP_INIT_PUSH: begin
				idx_q <= idx_q + pw_fnd[IW-1:0];
				rem_q <= rem_q - pw_fnd;
				fnd_q <= top_q;
			end
			OP_SCAN:   fnd_q <= fnd_q + 5'd1;
			OP_POPRD:  idx_q <= head_rd[IW-1:0];
			OP_SPLIT:  fnd_q <= fnd_m1;
			OP_BUD_RD: bud_q <= bud;
			OP_WALK_START: begin
				prev_q <= EMPTY;
				cur_q  <= head_rd;
			end
			OP_ADV: begin
				prev_q <= cur_q;
				cur_q  <= nl_rd_q;
			end
			OP_UNLINK: begin
				if (bud_q < idx_q) begin
					idx_q <= bud_q;
				end
				ord_q <= ord_q + 5'd1;
			end
			default: begin
			end
		endcase
		if (cmd.post) begin
			rsp_q.status       <= cmd.code;
			rsp_q.result_index <= cmd.take ? 10'(idx_q) : 10'd0;
		end
	end

	assign rsp = rsp_q;

	always_comb begin
		sts.clr_last   = clr_q == IW'(BLOCKS - 1);
		sts.init_bad   = ready_q || (cfg_q == '0) || (32'(cfg_q) > 32'(BLOCKS));
		sts.t_grow     = (top_q < 5'(ORDER_CAP)) && (two_top <= {1'b0, size_q});
		sts.fit        = (pw_fnd <= rem_q) && (({1'b0, idx_q} & (pw_fnd - SW'(1))) == '0);
		sts.rem_zero   = rem_q == '0;
		sts.alc_bad    = !ready_q || (ord_q > top_q);
		sts.head_empty = head_rd == EMPTY;
		sts.fnd_top    = fnd_q == top_q;
		sts.fnd_above  = fnd_q > ord_q;
		sts.free_bad   = !ready_q || big_q || ({1'b0, idx_q} >= size_q) || (ord_q > top_q);
		sts.mark_ok    = bm_rd_q == (8'd0 - 8'(ord_q) - 8'd2);
		sts.mrg_can    = (ord_q < top_q) && ({1'b0, bud} < size_q);
		sts.bud_free   = bm_rd_q == 8'(ord_q);
		sts.cur_end    = cur_q >= EMPTY;
		sts.cur_hit    = cur_q == {1'b0, bud_q};
	end

endmodule

@@ rtl/core/bba_ctrl.sv @@
// Controller of the buddy block allocator: sequences every request as datapath
// commands and owns the handshake state. Depends on bba_pkg.
module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic [1:0]    req_type,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  bba_pkg::sts_t sts,
	output bba_pkg::cmd_t cmd
);
	import bba_pkg::*;

	typedef enum logic [14:0] {
		S_CLEAR     = 15'b000000000000001,
		S_IDLE      = 15'b000000000000010,
		S_CHECK     = 15'b000000000000100,
		S_INIT_T    = 15'b000000000001000,
		S_INIT_O    = 15'b000000000010000,
		S_ALC_SCAN  = 15'b000000000100000,
		S_ALC_POP   = 15'b000000001000000,
		S_ALC_SPLIT = 15'b000000010000000,
		S_FREE_CHK  = 15'b000000100000000,
		S_MRG_BUD   = 15'b000001000000000,
		S_MRG_CHK   = 15'b000010000000000,
		S_WALK      = 15'b000100000000000,
		S_WALK_RD   = 15'b001000000000000,
		S_PUSH      = 15'b010000000000000,
		S_REPLY     = 15'b100000000000000
	} ctl_state_t;

	ctl_state_t state_q, nxt;
	logic [1:0] type_q, code_q, fin_code;
	logic       take_q, rsp_valid_q, fin, fin_take;

	always_comb begin
		nxt      = state_q;
		cmd      = '{op: OP_NOP, post: 1'b0, code: ST_OK, take: 1'b0};
		fin      = 1'b0;
		fin_code = ST_OK;
		fin_take = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLR;
				if (sts.clr_last) begin
					nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op = OP_LOAD;
					nxt    = S_CHECK;
				end
			end
			S_CHECK: begin
				case (type_q)
					REQ_INIT: begin
						if (sts.init_bad) begin
							fin      = 1'b1;
							fin_code = ST_BADARG;
						end else begin
							cmd.op = OP_INIT_START;
							nxt    = S_INIT_T;
						end
					end
					REQ_ALLOC: begin
						if (sts.alc_bad) begin
							fin      = 1'b1;
							fin_code = ST_BADARG;
						end else begin
							nxt = S_ALC_SCAN;
						end
					end
					REQ_FREE: begin
						if (sts.free_bad) begin
							fin      = 1'b1;
							fin_code = ST_BADARG;
						end else begin
							cmd.op = OP_FREE_RD;
							nxt    = S_FREE_CHK;
						end
					end
					default: begin
						fin      = 1'b1;
						fin_code = ST_BADARG;
					end
				endcase
			end
			S_INIT_T: begin
				if (sts.t_grow) begin
					cmd.op = OP_INIT_T;
				end else begin
					cmd.op = OP_INIT_ORD;
					nxt    = S_INIT_O;
				end
			end
			S_INIT_O: begin
				if (sts.rem_zero) begin
					cmd.op = OP_SET_READY;
					fin    = 1'b1;
				end else if (sts.fit) begin
					cmd.op = OP_INIT_PUSH;
				end else begin
					cmd.op = OP_FND_DEC;
				end
			end
			S_ALC_SCAN: begin
				if (!sts.head_empty) begin
					cmd.op = OP_POPRD;
					nxt    = S_ALC_POP;
				end else if (sts.fnd_top) begin
					fin      = 1'b1;
					fin_code = ST_NOMEM;
				end else begin
					cmd.op = OP_SCAN;
				end
			end
			S_ALC_POP: begin
				cmd.op = OP_POP;
				nxt    = S_ALC_SPLIT;
			end
			S_ALC_SPLIT: begin
				if (sts.fnd_above) begin
					cmd.op = OP_SPLIT;
				end else begin
					cmd.op   = OP_MARK;
					fin      = 1'b1;
					fin_take = 1'b1;
				end
			end
			S_FREE_CHK: begin
				if (!sts.mark_ok) begin
					fin      = 1'b1;
					fin_code = ST_NOTALLOC;
				end else begin
					cmd.op = OP_FREE_CLR;
					nxt    = S_MRG_BUD;
				end
			end
			S_MRG_BUD: begin
				if (sts.mrg_can) begin
					cmd.op = OP_BUD_RD;
					nxt    = S_MRG_CHK;
				end else begin
					nxt = S_PUSH;
				end
			end
			S_MRG_CHK: begin
				if (sts.bud_free) begin
					cmd.op = OP_WALK_START;
					nxt    = S_WALK;
				end else begin
					nxt = S_PUSH;
				end
			end
			S_WALK: begin
				if (sts.cur_end) begin
					nxt = S_PUSH;
				end else begin
					cmd.op = OP_NL_RD;
					nxt    = S_WALK_RD;
				end
			end
			S_WALK_RD: begin
				if (sts.cur_hit) begin
					cmd.op = OP_UNLINK;
					nxt    = S_MRG_BUD;
				end else begin
					cmd.op = OP_ADV;
					nxt    = S_WALK;
				end
			end
			S_PUSH: begin
				cmd.op = OP_PUSH;
				fin    = 1'b1;
			end
			S_REPLY: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.post = 1'b1;
					cmd.code = code_q;
					cmd.take = take_q;
					nxt      = S_IDLE;
				end
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
		if (fin) begin
			nxt = S_REPLY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
			type_q      <= REQ_INIT;
			code_q      <= ST_OK;
			take_q      <= 1'b0;
		end else begin
			state_q     <= nxt;
			rsp_valid_q <= cmd.post || (rsp_valid_q && !rsp_ready);
			if (state_q == S_IDLE && req_valid) begin
				type_q <= req_type;
			end
			if (fin) begin
				code_q <= fin_code;
				take_q <= fin_take;
			end
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;

endmodule

@@ rtl/core/buddy_block_allocator.sv @@
// Top level of the buddy block allocator: controller, datapath and a few checks.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
//
// Buddy allocator over a pool of BLOCKS equal blocks. Each request word on req
// (init, allocate or free) returns exactly one response word on rsp with a
// status and, for a successful allocation, the index of the block. The block
// works on one request at a time; the response sits in an output register, so
// the next request is taken as soon as the response is posted, even while it
// waits to be read. After reset the block map memory is swept to its reset
// value, one entry per cycle, and the block accepts no request until the sweep
// is done (configuration writes are taken throughout). A rejected request goes
// straight to its response; init finds the top order and then carves the pool
// into free blocks, stepping down one order at a time where a block does not fit;
// alloc scans the free lists upward past empty ones, pops a block and splits it
// down to the asked order; free checks the block's mark and then, at each merge
// level, walks the free list to unlink a free buddy before pushing the result.
// The usable_blocks register is written through cfg_valid/cfg_data, is always
// ready, and is only read at init.
module buddy_block_allocator #(
	parameter int BLOCKS    = bba_pkg::BLOCKS_DEF,
	parameter int ORDER_CAP = bba_pkg::ORDER_CAP_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  bba_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output bba_pkg::rsp_t             rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bba_pkg::CFG_W-1:0] cfg_data
);
	import bba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The register is a plain flop, so a write word is always taken.
	assign cfg_ready = 1'b1;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bba_datapath #(
		.BLOCKS    (BLOCKS),
		.ORDER_CAP (ORDER_CAP)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

	// Only one request is in work at a time: taking a word drops ready.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// Every failed request reports index zero.
	a_err_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.result_index == 10'd0)
		else $error("nonzero index on a failed request");

	// A response can never be posted in the cycle right after a request is taken.
	a_no_instant_reply: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("response posted without processing the request");

endmodule
